// ----- rtl/soc_pkg.sv -----
// Shared types and constants of the sensor offset calibrator.
// Depends on nothing; imported by soc_filt, the top level and the testbench.
package soc_pkg;

  localparam int CHANNELS = 7;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DATA_W   = 16;
  localparam int CNT_W    = 5;

  // Lowpass weights in Q16; they sum to exactly one.
  localparam logic [15:0] COEF_PREV_Q16 = 16'd58982;
  localparam logic [15:0] COEF_NOW_Q16  = 16'd6554;

  typedef enum logic [1:0] {
    OP_PRIME   = 2'd0,
    OP_CALIB   = 2'd1,
    OP_CORRECT = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_LP    = 3'd1,
    MODE_HP    = 3'd2,
    MODE_LP_HP = 3'd3,
    MODE_HP_LP = 3'd4
  } filt_mode_e;

  typedef enum logic [1:0] {
    CFG_FILTER_MODE   = 2'd0,
    CFG_FIRST_CHANNEL = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_MUL,
    S_DONE
  } state_e;

  // One channel's stored state.
  typedef struct packed {
    logic signed [DATA_W-1:0] offset;
    logic signed [DATA_W-1:0] lp;
    logic signed [DATA_W-1:0] hp;
  } chan_entry_t;

  // Outputs of one filter pass.
  typedef struct packed {
    logic signed [DATA_W-1:0] lp;
    logic signed [DATA_W-1:0] hp;
  } filt_res_t;

endpackage

// ----- rtl/soc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module soc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/soc_filt.sv -----
// One first-order filter pass: registered products, then sum and truncation.
// Depends on soc_pkg for coefficients and the result struct.
module soc_filt
  import soc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] now_i,
  input  logic signed [DATA_W-1:0] prev_i,
  output filt_res_t                res_o
);

  logic signed [32:0]       prod_prev_q;
  logic signed [32:0]       prod_now_q;
  logic signed [DATA_W-1:0] now_q;
  logic signed [33:0]       acc;
  logic signed [17:0]       quot;

  // Products are registered when a pass starts; the sum is formed from them in the following cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_prev_q <= 33'($signed({1'b0, COEF_PREV_Q16})) * 33'(prev_i);
      prod_now_q  <= 33'($signed({1'b0, COEF_NOW_Q16})) * 33'(now_i);
      now_q       <= now_i;
    end
  end

  always_comb begin
    acc  = 34'(prod_prev_q) + 34'(prod_now_q);
    quot = acc[33:16];
    // The shift floors; a negative value with a remainder moves up by one.
    if (acc[33] && (acc[15:0] != 16'd0)) begin
      quot = quot + 18'sd1;
    end
    res_o.lp = quot[DATA_W-1:0];
    res_o.hp = now_q - quot[DATA_W-1:0];
  end

endmodule

// ----- rtl/sensor_offset_calibrator.sv -----
// Top level of the sensor offset calibrator: sequencer, channel store, output register.
// Depends on soc_pkg, soc_ram and soc_filt.
// Each word runs IDLE, READ, SUM for each filter pass (MUL before a second one) and DONE,
// which loads the result register; no new word is taken until DONE hands off, a limit set by
// the read of the channel store and the shared multiply-and-sum filter unit, which the
// two-stage chains use twice; a stalled result word holds the sequencer and adds the stall.
// Reset clears the registers to filter_mode 0, first_channel 0, channel_count 7.
module sensor_offset_calibrator
  import soc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [2:0]               channel_i,
  input  logic signed [DATA_W-1:0] sample_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic signed [DATA_W-1:0] offset_value_o,
  output logic                     status_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [2:0]               cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user is to send them only while
  // the block is idle (the block does not enforce this), so no word in flight sees a change.
  // ---------------------------------------------------------------------------
  logic [2:0] mode_cfg_q;
  logic [2:0] first_cfg_q;
  logic [2:0] count_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_cfg_q  <= MODE_NONE;
      first_cfg_q <= 3'd0;
      count_cfg_q <= 3'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FILTER_MODE:   mode_cfg_q  <= cfg_data_i;
        CFG_FIRST_CHANNEL: first_cfg_q <= cfg_data_i;
        CFG_CHANNEL_COUNT: count_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decode of an incoming word. A channel at or beyond CHANNELS does not
  // exist; prime and calibrate must also fall inside the configured window,
  // and a window that runs past the last channel or is empty rejects them all.
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic               accept;
  logic [CNT_W-1:0]   ch_ext;
  logic [CNT_W-1:0]   win_end;
  logic               ch_exists;
  logic               cfg_ok;
  logic               ch_in_range;
  logic [CH_W-1:0]    ch_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    ch_ext      = CNT_W'(channel_i);
    win_end     = CNT_W'(first_cfg_q) + CNT_W'(count_cfg_q);
    ch_exists   = ch_ext < CNT_W'(CHANNELS);
    cfg_ok      = (count_cfg_q != 3'd0) && (win_end <= CNT_W'(CHANNELS));
    ch_in_range = ch_exists && cfg_ok && (channel_i >= first_cfg_q) && (ch_ext < win_end);
    ch_idx      = ch_exists ? ch_ext[CH_W-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Word registers held for the whole sequence of one item.
  // ---------------------------------------------------------------------------
  logic [1:0]               op_q;
  logic [CH_W-1:0]          idx_q;
  logic signed [DATA_W-1:0] x_q;
  logic [2:0]               mode_q;
  logic                     exists_q;
  logic                     in_range_q;
  logic signed [DATA_W-1:0] off_q;
  logic signed [DATA_W-1:0] lp_q;
  logic signed [DATA_W-1:0] hp_q;
  logic signed [DATA_W-1:0] res_q;
  logic                     stat_q;
  logic                     we_q;
  logic                     upd_off_q;
  logic                     pass_q;

  // ---------------------------------------------------------------------------
  // Channel store: offset and both filter states in one entry per channel.
  // Only the offset has a defined reset, so each entry carries a valid bit
  // and an entry never written reads its offset as zero.
  // ---------------------------------------------------------------------------
  logic                ram_we;
  chan_entry_t         ram_wdata;
  logic [$bits(chan_entry_t)-1:0] ram_rdata;
  chan_entry_t         rd_ent;
  logic [CHANNELS-1:0] off_vld_q;
  logic signed [DATA_W-1:0] off_eff;

  soc_ram #(
    .WIDTH ($bits(chan_entry_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ch_idx),
    .rdata_o (ram_rdata)
  );

  assign rd_ent  = chan_entry_t'(ram_rdata);
  assign off_eff = off_vld_q[idx_q] ? rd_ent.offset : '0;

  // Mode groupings used by the sequencer.
  logic mode_lp_first;
  logic mode_two_pass;
  logic mode_filters;

  assign mode_lp_first = (mode_q == MODE_LP) || (mode_q == MODE_LP_HP);
  assign mode_two_pass = (mode_q == MODE_LP_HP) || (mode_q == MODE_HP_LP);
  assign mode_filters  = (mode_q == MODE_LP) || (mode_q == MODE_HP) ||
                         (mode_q == MODE_LP_HP) || (mode_q == MODE_HP_LP);

  logic prime_go;
  logic calib_go;
  logic corr_go;

  assign prime_go = (op_q == OP_PRIME) && in_range_q;
  assign calib_go = (op_q == OP_CALIB) && in_range_q;
  assign corr_go  = (op_q == OP_CORRECT) && exists_q;

  // ---------------------------------------------------------------------------
  // Shared filter unit. A pass starts in READ (first stage of the chain) or
  // in MUL (second stage), and its result is taken in SUM.
  // ---------------------------------------------------------------------------
  logic                     filt_start;
  logic signed [DATA_W-1:0] filt_now;
  logic signed [DATA_W-1:0] filt_prev;
  filt_res_t                filt_res;

  soc_filt u_filt (
    .clk_i   (clk_i),
    .start_i (filt_start),
    .now_i   (filt_now),
    .prev_i  (filt_prev),
    .res_o   (filt_res)
  );

  // ---------------------------------------------------------------------------
  // Offset update: the average of filtered value and old offset, truncated
  // toward zero.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W:0]   off_sum;
  logic signed [DATA_W:0]   off_adj;
  logic signed [DATA_W-1:0] off_new;
  logic signed [DATA_W-1:0] off_out;

  always_comb begin
    off_sum = (DATA_W+1)'(res_q) + (DATA_W+1)'(off_q);
    off_adj = off_sum[DATA_W] ? (off_sum + 17'sd1) : off_sum;
    off_new = off_adj[DATA_W:1];
    off_out = upd_off_q ? off_new : off_q;
  end

  // ---------------------------------------------------------------------------
  // Output register. It loads when the sequence ends and the previous word
  // has gone or goes in this cycle.
  // ---------------------------------------------------------------------------
  logic                     out_valid_q;
  logic                     out_load;
  logic signed [DATA_W-1:0] out_res_q;
  logic signed [DATA_W-1:0] out_off_q;
  logic                     out_stat_q;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign offset_value_o = out_off_q;
  assign status_o       = out_stat_q;

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a word and reads its channel, READ classifies it
  // and starts the first filter pass if there is one, SUM collects a pass, MUL starts the
  // second pass of a two-stage chain, DONE writes back and hands the result
  // to the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    filt_start = 1'b0;
    filt_now   = x_q;
    filt_prev  = '0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '{offset: off_out, lp: lp_q, hp: hp_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DONE;
        if (prime_go) begin
          filt_start = 1'b1;
          state_d    = S_SUM;
        end else if (calib_go && mode_filters) begin
          filt_start = 1'b1;
          filt_prev  = mode_lp_first ? rd_ent.lp : rd_ent.hp;
          state_d    = S_SUM;
        end
      end
      S_SUM: begin
        state_d = (calib_go && mode_two_pass && !pass_q) ? S_MUL : S_DONE;
      end
      S_MUL: begin
        filt_start = 1'b1;
        filt_now   = (mode_q == MODE_LP_HP) ? lp_q : hp_q;
        filt_prev  = (mode_q == MODE_LP_HP) ? hp_q : lp_q;
        state_d    = S_SUM;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          ram_we   = we_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control flags of the word in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      we_q      <= 1'b0;
      upd_off_q <= 1'b0;
      pass_q    <= 1'b0;
    end else begin
      if (accept) begin
        we_q      <= 1'b0;
        upd_off_q <= 1'b0;
        pass_q    <= 1'b0;
      end else if (state_q == S_READ) begin
        // Prime seeds in every mode; calibrate writes only for a known mode.
        we_q      <= prime_go || (calib_go && (mode_filters || mode_q == MODE_NONE));
        upd_off_q <= calib_go && (mode_filters || mode_q == MODE_NONE);
      end else if (state_q == S_MUL) begin
        pass_q <= 1'b1;
      end
    end
  end

  // Payload of the word in flight.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_i;
      idx_q      <= ch_idx;
      x_q        <= sample_i;
      mode_q     <= mode_cfg_q;
      exists_q   <= ch_exists;
      in_range_q <= ch_in_range;
    end else if (state_q == S_READ) begin
      off_q  <= exists_q ? off_eff : '0;
      lp_q   <= rd_ent.lp;
      hp_q   <= rd_ent.hp;
      stat_q <= !(corr_go || prime_go || calib_go);
      if (corr_go) begin
        res_q <= x_q - off_eff;
      end else if (prime_go || calib_go) begin
        res_q <= x_q;
      end else begin
        res_q <= '0;
      end
    end else if (state_q == S_SUM) begin
      if (op_q == OP_PRIME) begin
        lp_q <= filt_res.lp;
        hp_q <= filt_res.hp;
        if ((mode_q == MODE_LP) || (mode_q == MODE_HP_LP)) begin
          res_q <= filt_res.lp;
        end else if ((mode_q == MODE_HP) || (mode_q == MODE_LP_HP)) begin
          res_q <= filt_res.hp;
        end
      end else begin
        case (mode_q)
          MODE_LP: begin
            lp_q  <= filt_res.lp;
            res_q <= filt_res.lp;
          end
          MODE_HP: begin
            hp_q  <= filt_res.hp;
            res_q <= filt_res.hp;
          end
          MODE_LP_HP: begin
            if (!pass_q) begin
              lp_q <= filt_res.lp;
            end else begin
              hp_q  <= filt_res.hp;
              res_q <= filt_res.hp;
            end
          end
          MODE_HP_LP: begin
            if (!pass_q) begin
              hp_q <= filt_res.hp;
            end else begin
              lp_q  <= filt_res.lp;
              res_q <= filt_res.lp;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Offset valid bits: an entry's offset is defined once it has been written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q <= '0;
    end else if (ram_we) begin
      off_vld_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q  <= res_q;
      out_off_q  <= off_out;
      out_stat_q <= stat_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted word did not move to the read state");

  a_write_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_DONE) && out_load))
    else $error("channel store written outside the hand-off");

  a_second_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> ((state_q == S_SUM) && pass_q))
    else $error("second filter pass not collected");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_value_o == '0))
    else $error("rejected word carries a nonzero result");

endmodule

// ----- sim/sensor_offset_calibrator_tb.sv -----
// Self-checking testbench of sensor_offset_calibrator: directed table, then randomized phases.
// Depends on soc_pkg and the block's RTL; it holds its own filter and offset predictor.
module sensor_offset_calibrator_tb;
  import soc_pkg::*;

  // Codes that the field widths allow but the package leaves unnamed.
  localparam logic [1:0] OP_UNKNOWN      = 2'd3;
  localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;
  localparam logic [1:0] CFG_UNUSED      = 2'd3;
  localparam logic [2:0] CH_ABSENT       = 3'd7;

  localparam int RANDOM_WORDS = 1350;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_TAIL   = 16;

  // One result word, compared field by field.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] offset;
    logic                     status;
  } result_t;

  // One row of the directed table: the register setting it runs under, the input word,
  // and, where the answer is obvious, the result typed in by hand.
  typedef struct {
    logic [2:0]               mode;
    logic [2:0]               first;
    logic [2:0]               count;
    logic [1:0]               op;
    logic [2:0]               ch;
    logic signed [DATA_W-1:0] x;
    bit                       typed;
    result_t                  want;
  } plan_row_t;

  // How the result side applies back-pressure during one stretch of cycles.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_e;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               opcode_i       = '0;
  logic [2:0]               channel_i      = '0;
  logic signed [DATA_W-1:0] sample_i       = '0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [DATA_W-1:0] result_value_o;
  logic signed [DATA_W-1:0] offset_value_o;
  logic                     status_o;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i    = '0;
  logic [2:0]               cfg_data_i     = '0;

  sensor_offset_calibrator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .offset_value_o (offset_value_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the register copy and the per-channel store as the block should hold
  // them. A channel counts as primed once a prime word has seeded both of its filter states.
  logic [2:0]               cfg_mode  = MODE_NONE;
  logic [2:0]               cfg_first = 3'd0;
  logic [2:0]               cfg_count = 3'd7;
  logic signed [DATA_W-1:0] offset_mem [CHANNELS];
  logic signed [DATA_W-1:0] lp_mem     [CHANNELS];
  logic signed [DATA_W-1:0] hp_mem     [CHANNELS];
  bit                       primed     [CHANNELS];

  result_t results_due [$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;
  int      burst_left     = 0;

  initial begin
    foreach (offset_mem[i]) begin
      offset_mem[i] = '0;
      lp_mem[i]     = '0;
      hp_mem[i]     = '0;
      primed[i]     = 1'b0;
    end
  end

  // Lowpass in Q16: the exact weighted sum divided by one in Q16, truncated toward zero.
  // The weights sum to one, so the quotient always fits 16 bits.
  function automatic logic signed [DATA_W-1:0] lowpass_q16(logic signed [DATA_W-1:0] now,
                                                            logic signed [DATA_W-1:0] prev);
    longint acc;
    acc = longint'(COEF_PREV_Q16) * longint'(prev) + longint'(COEF_NOW_Q16) * longint'(now);
    return DATA_W'(acc / 65536);
  endfunction

  // Highpass is the input less its lowpass, wrapped to 16 bits.
  function automatic logic signed [DATA_W-1:0] highpass_q16(logic signed [DATA_W-1:0] now,
                                                             logic signed [DATA_W-1:0] prev);
    return now - lowpass_q16(now, prev);
  endfunction

  // Prime and calibrate may only touch channels inside a sane configured window.
  function automatic bit chan_in_range(logic [2:0] ch);
    int lo;
    int hi;
    lo = int'(cfg_first);
    hi = int'(cfg_first) + int'(cfg_count);
    return (ch < CHANNELS) && (cfg_count != 0) && (hi <= CHANNELS) && (ch >= lo) && (ch < hi);
  endfunction

  // A calibrate word reads the stored filter states only in a known filter mode.
  function automatic bit calib_reads_state(logic [2:0] ch);
    return chan_in_range(ch) && (cfg_mode >= MODE_LP) && (cfg_mode <= MODE_HP_LP);
  endfunction

  // Works out the result word of one accepted input word and updates the predictor state.
  function automatic result_t calibrator_result(logic [1:0] op, logic [2:0] ch,
                                                logic signed [DATA_W-1:0] x);
    result_t                  r;
    logic signed [DATA_W-1:0] lp;
    logic signed [DATA_W-1:0] hp;
    logic signed [DATA_W-1:0] filt;
    int                       avg;
    bit                       known;
    r = '0;
    if (op == OP_CORRECT && ch < CHANNELS) begin
      // Correction works on every existing channel, whatever the window.
      r.value = x - offset_mem[ch];
    end else if (op == OP_PRIME && chan_in_range(ch)) begin
      lp         = lowpass_q16(x, '0);
      hp         = x - lp;
      lp_mem[ch] = lp;
      hp_mem[ch] = hp;
      primed[ch] = 1'b1;
      // The reported seed is that of the last filter in the chain.
      case (cfg_mode)
        MODE_LP, MODE_HP_LP: r.value = lp;
        MODE_HP, MODE_LP_HP: r.value = hp;
        default:             r.value = x;
      endcase
    end else if (op == OP_CALIB && chan_in_range(ch)) begin
      filt  = x;
      known = 1'b1;
      case (cfg_mode)
        MODE_NONE: ;
        MODE_LP: begin
          filt       = lowpass_q16(x, lp_mem[ch]);
          lp_mem[ch] = filt;
        end
        MODE_HP: begin
          filt       = highpass_q16(x, hp_mem[ch]);
          hp_mem[ch] = filt;
        end
        MODE_LP_HP: begin
          lp_mem[ch] = lowpass_q16(x, lp_mem[ch]);
          filt       = highpass_q16(lp_mem[ch], hp_mem[ch]);
          hp_mem[ch] = filt;
        end
        MODE_HP_LP: begin
          hp_mem[ch] = highpass_q16(x, hp_mem[ch]);
          filt       = lowpass_q16(hp_mem[ch], lp_mem[ch]);
          lp_mem[ch] = filt;
        end
        default: known = 1'b0;
      endcase
      r.value = filt;
      // The new offset is the mean of the filtered value and the old offset.
      if (known) begin
        avg            = (int'(filt) + int'(offset_mem[ch])) / 2;
        offset_mem[ch] = avg[DATA_W-1:0];
      end
    end else begin
      r.status = 1'b1;
    end
    r.offset = (ch < CHANNELS) ? offset_mem[ch] : '0;
    return r;
  endfunction

  // Drives one input word, keeps it steady until it is taken, then records its expected
  // result. The sender runs in bursts; before each burst the valid drops for a random gap.
  task automatic send_word(logic [1:0] op, logic [2:0] ch, logic signed [DATA_W-1:0] x,
                           bit typed, result_t want);
    result_t got;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    opcode_i   <= op;
    channel_i  <= ch;
    sample_i   <= x;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = calibrator_result(op, ch, x);
    results_due.push_back(typed ? want : got);
  endtask

  // Writes one register and mirrors it into the predictor once the write is taken.
  // The valid stays high so that back-to-back writes need no extra cycle.
  task automatic write_reg(logic [1:0] idx, logic [2:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FILTER_MODE:   cfg_mode  = data;
      CFG_FIRST_CHANNEL: cfg_first = data;
      CFG_CHANNEL_COUNT: cfg_count = data;
      default: ;
    endcase
  endtask

  // Registers change only while the block is idle: the input side is held off and every
  // outstanding result must have come back first.
  task automatic apply_config(logic [2:0] m, logic [2:0] f, logic [2:0] c);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    write_reg(CFG_FILTER_MODE, m);
    write_reg(CFG_FIRST_CHANNEL, f);
    write_reg(CFG_CHANNEL_COUNT, c);
    cfg_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // Samples lean on the extremes, zero and minus one, and small values.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return ($urandom_range(0, 1) == 1) ? 16'sh0000 : 16'shFFFF;
      3, 4:    return DATA_W'($urandom_range(0, 400) - 200);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Most words go to channels inside the window so that the filters keep running;
  // the rest land anywhere, the absent channel included.
  function automatic logic [2:0] pick_channel();
    if (cfg_count != 0 && int'(cfg_first) + int'(cfg_count) <= CHANNELS &&
        $urandom_range(0, 9) < 8)
      return cfg_first + 3'($urandom_range(0, int'(cfg_count) - 1));
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic note_mismatch(string field, int want, int got);
    mismatch_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Directed table. Rows whose result is plain from the rules carry it typed in; the
  // filter rows are left to the predictor. The register columns set the window and mode.
  plan_row_t plan [0:24] = '{
    // After reset: offsets are zero, so a correction returns the sample itself.
    '{MODE_NONE, 3'd0, 3'd7, OP_CORRECT, 3'd0, 16'sh7FFF, 1'b1, '{16'sh7FFF, 16'sh0, 1'b0}},
    '{MODE_NONE, 3'd0, 3'd7, OP_CORRECT, 3'd6, 16'sh8000, 1'b1, '{16'sh8000, 16'sh0, 1'b0}},
    // The absent channel and the unknown opcode are always rejected.
    '{MODE_NONE, 3'd0, 3'd7, OP_CORRECT, CH_ABSENT, 16'sd1234, 1'b1, '{16'sh0, 16'sh0, 1'b1}},
    '{MODE_NONE, 3'd0, 3'd7, OP_UNKNOWN, 3'd3, 16'sd5, 1'b1, '{16'sh0, 16'sh0, 1'b1}},
    // With no filter a prime echoes the sample.
    '{MODE_NONE, 3'd0, 3'd7, OP_PRIME, 3'd0, 16'sh7FFF, 1'b1, '{16'sh7FFF, 16'sh0, 1'b0}},
    '{MODE_NONE, 3'd0, 3'd7, OP_PRIME, CH_ABSENT, -16'sd1, 1'b1, '{16'sh0, 16'sh0, 1'b1}},
    // Unfiltered calibration halves the extremes into the offsets.
    '{MODE_NONE, 3'd0, 3'd7, OP_CALIB, 3'd0, 16'sh7FFF, 1'b1,
      '{16'sh7FFF, 16'sd16383, 1'b0}},
    '{MODE_NONE, 3'd0, 3'd7, OP_CALIB, 3'd1, 16'sh8000, 1'b1,
      '{16'sh8000, -16'sd16384, 1'b0}},
    // Corrections that wrap past the 16-bit range.
    '{MODE_NONE, 3'd0, 3'd7, OP_CORRECT, 3'd0, 16'sh8000, 1'b0, '0},
    '{MODE_NONE, 3'd0, 3'd7, OP_CORRECT, 3'd1, 16'sh7FFF, 1'b0, '0},
    // Each filter chain: seed a channel, then run one calibration on it.
    '{MODE_LP,    3'd0, 3'd7, OP_PRIME, 3'd2, 16'sh7FFF, 1'b0, '0},
    '{MODE_LP,    3'd0, 3'd7, OP_CALIB, 3'd2, 16'sh8000, 1'b0, '0},
    '{MODE_HP,    3'd0, 3'd7, OP_PRIME, 3'd3, 16'sh8000, 1'b0, '0},
    '{MODE_HP,    3'd0, 3'd7, OP_CALIB, 3'd3, 16'sh7FFF, 1'b0, '0},
    '{MODE_LP_HP, 3'd0, 3'd7, OP_PRIME, 3'd4, 16'sh7FFF, 1'b0, '0},
    '{MODE_LP_HP, 3'd0, 3'd7, OP_CALIB, 3'd4, 16'sh8000, 1'b0, '0},
    '{MODE_HP_LP, 3'd0, 3'd7, OP_PRIME, 3'd5, 16'sh8000, 1'b0, '0},
    '{MODE_HP_LP, 3'd0, 3'd7, OP_CALIB, 3'd5, 16'sh7FFF, 1'b0, '0},
    // An unknown filter mode echoes the sample and leaves the offset alone.
    '{MODE_RSVD_LAST, 3'd0, 3'd7, OP_PRIME, 3'd6, 16'sd100, 1'b1, '{16'sd100, 16'sh0, 1'b0}},
    '{MODE_RSVD_LAST, 3'd0, 3'd7, OP_CALIB, 3'd6, -16'sd5, 1'b1, '{-16'sd5, 16'sh0, 1'b0}},
    // Window of channels two to four: below, at the top edge, and just above.
    '{MODE_NONE, 3'd2, 3'd3, OP_CALIB, 3'd1, 16'sd7, 1'b1, '{16'sh0, -16'sd16384, 1'b1}},
    '{MODE_NONE, 3'd2, 3'd3, OP_CALIB, 3'd4, -16'sd7, 1'b0, '0},
    '{MODE_NONE, 3'd2, 3'd3, OP_PRIME, 3'd5, 16'sd0, 1'b0, '0},
    // A window past the last channel, and an empty window, reject prime and calibrate words.
    '{MODE_LP, 3'd6, 3'd2, OP_PRIME, 3'd6, 16'sd1, 1'b1, '{16'sh0, 16'sh0, 1'b1}},
    '{MODE_LP, 3'd0, 3'd0, OP_CALIB, 3'd0, 16'sd1, 1'b1, '{16'sh0, 16'sd16383, 1'b1}}
  };

  // Stimulus: reset, the directed table, then random phases with fresh register settings.
  initial begin
    logic [1:0]               op;
    logic [2:0]               ch;
    logic [2:0]               m;
    logic [2:0]               f;
    logic [2:0]               c;
    logic signed [DATA_W-1:0] x;
    int                       sent;
    int                       phase;
    int                       phase_len;
    int                       r;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to the unused index must leave every register as it was.
    write_reg(CFG_UNUSED, 3'b111);
    cfg_valid_i <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].mode != cfg_mode || plan[i].first != cfg_first || plan[i].count != cfg_count)
        apply_config(plan[i].mode, plan[i].first, plan[i].count);
      send_word(plan[i].op, plan[i].ch, plan[i].x, plan[i].typed, plan[i].want);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      // The first phases pin the extremes of the registers; the rest draw at random,
      // mostly a sane window and now and then a broken one.
      case (phase)
        0: apply_config(MODE_LP_HP, 3'd6, 3'd1);
        1: apply_config(MODE_HP, 3'd0, 3'd7);
        2: apply_config(MODE_RSVD_FIRST, 3'd7, 3'd7);
        default: begin
          r = $urandom_range(0, 11);
          m = (r < 10) ? 3'(r % 5) : 3'($urandom_range(5, 7));
          if ($urandom_range(0, 6) == 0) begin
            f = 3'($urandom_range(0, 7));
            c = 3'($urandom_range(0, 7));
          end else begin
            f = 3'($urandom_range(0, CHANNELS - 1));
            c = 3'($urandom_range(1, CHANNELS - int'(f)));
          end
          apply_config(m, f, c);
        end
      endcase
      phase_len = $urandom_range(40, 160);
      if (phase_len > RANDOM_WORDS - sent)
        phase_len = RANDOM_WORDS - sent;
      repeat (phase_len) begin
        r  = $urandom_range(0, 99);
        op = (r < 35) ? OP_CALIB : (r < 60) ? OP_CORRECT : (r < 96) ? OP_PRIME : OP_UNKNOWN;
        ch = pick_channel();
        x  = pick_sample();
        // Filter state is undefined until a prime seeds it, so a calibration that would
        // read an unseeded channel becomes the prime that seeds it.
        if (op == OP_CALIB && ch < CHANNELS && calib_reads_state(ch) && !primed[ch])
          op = OP_PRIME;
        send_word(op, ch, x, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    // A few more cycles catch any stray result word after the last expected one.
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Result side: checks each accepted word against the oldest expectation and drives
  // the stall line. The stall follows styles, each held for a random stretch: none at all,
  // light random, heavy with capped runs, and a fixed period.
  rx_style_e rx_style     = RX_FREE;
  int        rx_left      = 0;
  int        rx_period    = 3;
  int        stall_run    = 0;

  always @(posedge clk_i) begin : result_side
    result_t head;
    logic    hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing expected: value %0d, offset %0d, status %0d",
                   $time, result_value_o, offset_value_o, status_o);
        end else begin
          head = results_due.pop_front();
          if (result_value_o !== head.value)
            note_mismatch("result_value", head.value, result_value_o);
          if (offset_value_o !== head.offset)
            note_mismatch("offset_value", head.offset, offset_value_o);
          if (status_o !== head.status)
            note_mismatch("status", head.status, status_o);
        end
      end

      if (rx_left == 0) begin
        rx_style  = rx_style_e'($urandom_range(0, 3));
        rx_left   = $urandom_range(50, 300);
        rx_period = $urandom_range(2, 7);
      end
      rx_left--;
      case (rx_style)
        RX_RANDOM:   hold = ($urandom_range(0, 9) < 3);
        RX_HEAVY:    hold = (stall_run < 16) && ($urandom_range(0, 3) != 0);
        RX_PERIODIC: hold = ((rx_left % rx_period) == 0);
        default:     hold = 1'b0;
      endcase
      stall_run = hold ? stall_run + 1 : 0;
      out_stall_i <= hold;
    end
  end

  // Watchdog: a long stretch with no word taken on any channel means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/soc_pkg.sv
rtl/soc_ram.sv
rtl/soc_filt.sv
rtl/sensor_offset_calibrator.sv
sim/sensor_offset_calibrator_tb.sv
